// File: rtl/tucst_pkg.sv
package tucst_pkg;

	localparam int MaxUnits = 16;
	localparam int ExtW = 4;

	typedef logic [ExtW-1:0] ext_t;

	typedef enum logic [1:0] {
		K_PICKUP = 2'd0,
		K_HANGUP = 2'd1,
		K_DIAL   = 2'd2,
		K_CHAT   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		M_ONHOOK    = 3'd0,
		M_RINGING   = 3'd1,
		M_DIALTONE  = 3'd2,
		M_RINGBACK  = 3'd3,
		M_BUSY      = 3'd4,
		M_CONNECTED = 3'd5,
		M_ERROR     = 3'd6
	} mode_t;

	typedef enum logic [1:0] {
		R_NOTICE = 2'd0,
		R_CHAT   = 2'd1,
		R_REJECT = 2'd2
	} rtype_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_RDX,
		B_EXEC,
		B_SECOND
	} bstate_t;

	// classified event as it sits in the command queue
	typedef struct packed {
		kind_t kind;
		ext_t  unit;
		ext_t  target;
		logic  known;
		logic  bad;
	} item_t;

	typedef struct packed {
		rtype_t rtype;
		ext_t   dest;
		mode_t  state;
		ext_t   peer;
		logic   err;
		logic   last;
	} result_t;

	typedef struct packed {
		mode_t mode;
		ext_t  peer;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

// File: rtl/tucst_fifo.sv
module tucst_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  logic [WIDTH-1:0]       wdata,
	input  logic                   pop,
	output logic [WIDTH-1:0]       rdata,
	output tucst_pkg::fifo_stat_t  stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign stat.full  = (cnt_q == CW'(DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign rdata      = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// File: rtl/tucst_front.sv
module tucst_front #(
	parameter int UNIT_COUNT = 16
) (
	input  logic                  valid,
	input  logic [1:0]            kind,
	input  logic [3:0]            unit,
	input  logic [3:0]            target_unit,
	input  logic                  target_known,
	input  tucst_pkg::fifo_stat_t q_stat,
	output logic                  stall,
	output logic                  push,
	output tucst_pkg::item_t      item
);

	assign stall = q_stat.full;
	assign push  = valid && !q_stat.full;

	// range-check extensions up front so the back end only sees clean indexes
	always_comb begin
		item.kind   = tucst_pkg::kind_t'(kind);
		item.unit   = unit;
		item.target = target_unit;
		item.known  = target_known && (int'(target_unit) < UNIT_COUNT);
		item.bad    = (int'(unit) >= UNIT_COUNT);
	end

endmodule

// File: rtl/tucst_back.sv
module tucst_back #(
	parameter int UNIT_COUNT = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tucst_pkg::fifo_stat_t cmd_stat,
	input  tucst_pkg::item_t      cmd_item,
	output logic                  cmd_pop,
	input  tucst_pkg::fifo_stat_t res_stat,
	output logic                  res_push,
	output tucst_pkg::result_t    res
);

	localparam int Depth = (UNIT_COUNT < tucst_pkg::MaxUnits) ? UNIT_COUNT : tucst_pkg::MaxUnits;
	localparam int IW    = $clog2(Depth);

	function automatic logic [IW-1:0] to_idx(tucst_pkg::ext_t e);
		return e[IW-1:0];
	endfunction

	function automatic tucst_pkg::result_t mk(tucst_pkg::rtype_t rt, tucst_pkg::ext_t dest,
			tucst_pkg::mode_t st, tucst_pkg::ext_t peer, logic err);
		tucst_pkg::result_t r;
		r.rtype = rt;
		r.dest  = dest;
		r.state = st;
		r.peer  = peer;
		r.err   = err;
		r.last  = 1'b0;
		return r;
	endfunction

	tucst_pkg::bstate_t state_q, state_d;
	tucst_pkg::item_t   item_q;
	tucst_pkg::entry_t  mem [Depth];
	tucst_pkg::entry_t  rdata_q;
	logic [Depth-1:0]   written_q, link_q;

	tucst_pkg::mode_t   mode_u_q;
	logic               lnk_u_q;
	tucst_pkg::ext_t    peer_u_q;
	tucst_pkg::ext_t    x_q;
	logic [IW-1:0]      ix_q;

	tucst_pkg::result_t r1_q;
	logic               wx_q;
	tucst_pkg::entry_t  wx_entry_q;

	logic [IW-1:0]      iu;
	tucst_pkg::mode_t   mode_u, mode_x;
	tucst_pkg::ext_t    x_sel;
	logic               x_ok;
	logic               lnk_x;

	logic               rd_en;
	logic [IW-1:0]      rd_addr;
	logic               we;
	logic [IW-1:0]      wa;
	tucst_pkg::entry_t  wd;
	logic               commit;

	tucst_pkg::result_t cur, r0, r1;
	logic               two, wu, wx, lu_clr, lu_set, lx_clr, lx_set;
	tucst_pkg::entry_t  wu_entry, wx_entry;

	assign iu     = item_q.bad ? '0 : to_idx(item_q.unit);
	assign mode_u = written_q[iu] ? rdata_q.mode : tucst_pkg::M_ONHOOK;
	assign x_sel  = (item_q.kind == tucst_pkg::K_DIAL) ? item_q.target : rdata_q.peer;
	assign x_ok   = !item_q.bad &&
	                ((item_q.kind == tucst_pkg::K_DIAL) ? item_q.known : link_q[iu]);
	assign mode_x = written_q[ix_q] ? rdata_q.mode : tucst_pkg::M_ONHOOK;
	assign lnk_x  = link_q[ix_q];

	// event decode: valid in B_EXEC, when rdata_q holds the second entry
	always_comb begin
		cur = mk(tucst_pkg::R_NOTICE, item_q.unit, mode_u_q,
			(mode_u_q == tucst_pkg::M_CONNECTED && lnk_u_q) ? peer_u_q : '0, 1'b0);
		r0       = cur;
		r1       = cur;
		two      = 1'b0;
		wu       = 1'b0;
		wx       = 1'b0;
		lu_clr   = 1'b0;
		lu_set   = 1'b0;
		lx_clr   = 1'b0;
		lx_set   = 1'b0;
		wu_entry = '{mode: mode_u_q, peer: peer_u_q};
		wx_entry = '{mode: mode_x, peer: rdata_q.peer};
		if (item_q.bad) begin
			r0 = mk(tucst_pkg::R_REJECT, item_q.unit, tucst_pkg::M_ONHOOK, '0, 1'b1);
		end else begin
			case (item_q.kind)
				tucst_pkg::K_PICKUP: begin
					if (mode_u_q == tucst_pkg::M_ONHOOK) begin
						wu = 1'b1;
						wu_entry.mode = tucst_pkg::M_DIALTONE;
						r0 = mk(tucst_pkg::R_NOTICE, item_q.unit, tucst_pkg::M_DIALTONE, '0, 1'b0);
					end else if (mode_u_q == tucst_pkg::M_RINGING) begin
						wu = 1'b1;
						wu_entry.mode = tucst_pkg::M_CONNECTED;
						if (lnk_u_q) begin
							wx  = 1'b1;
							two = 1'b1;
							wx_entry.mode = tucst_pkg::M_CONNECTED;
							r0 = mk(tucst_pkg::R_NOTICE, item_q.unit, tucst_pkg::M_CONNECTED,
								x_q, 1'b0);
							r1 = mk(tucst_pkg::R_NOTICE, x_q, tucst_pkg::M_CONNECTED,
								item_q.unit, 1'b0);
						end else begin
							r0 = mk(tucst_pkg::R_NOTICE, item_q.unit, tucst_pkg::M_CONNECTED,
								'0, 1'b0);
						end
					end
				end
				tucst_pkg::K_HANGUP: begin
					wu = 1'b1;
					wu_entry.mode = tucst_pkg::M_ONHOOK;
					r0 = mk(tucst_pkg::R_NOTICE, item_q.unit, tucst_pkg::M_ONHOOK, '0, 1'b0);
					if (mode_u_q == tucst_pkg::M_CONNECTED || mode_u_q == tucst_pkg::M_RINGING ||
							mode_u_q == tucst_pkg::M_RINGBACK) begin
						lu_clr = 1'b1;
						if (lnk_u_q) begin
							wx     = 1'b1;
							two    = 1'b1;
							lx_clr = 1'b1;
							// caller hanging up during ring back drops the callee back on hook; else the peer gets dial tone
							wx_entry.mode = (mode_u_q == tucst_pkg::M_RINGBACK) ?
								tucst_pkg::M_ONHOOK : tucst_pkg::M_DIALTONE;
							r1 = mk(tucst_pkg::R_NOTICE, x_q, wx_entry.mode, '0, 1'b0);
						end
					end
				end
				tucst_pkg::K_DIAL: begin
					if (!item_q.known) begin
						if (mode_u_q == tucst_pkg::M_DIALTONE) begin
							wu = 1'b1;
							wu_entry.mode = tucst_pkg::M_ERROR;
							r0 = mk(tucst_pkg::R_NOTICE, item_q.unit, tucst_pkg::M_ERROR, '0, 1'b1);
						end
					end else if (mode_u_q == tucst_pkg::M_DIALTONE) begin
						if (item_q.target == item_q.unit || lnk_x ||
								mode_x != tucst_pkg::M_ONHOOK) begin
							wu = 1'b1;
							wu_entry.mode = tucst_pkg::M_BUSY;
							r0 = mk(tucst_pkg::R_NOTICE, item_q.unit, tucst_pkg::M_BUSY, '0, 1'b0);
						end else begin
							wu     = 1'b1;
							wx     = 1'b1;
							two    = 1'b1;
							lu_set = 1'b1;
							lx_set = 1'b1;
							wu_entry = '{mode: tucst_pkg::M_RINGBACK, peer: item_q.target};
							wx_entry = '{mode: tucst_pkg::M_RINGING, peer: item_q.unit};
							r0 = mk(tucst_pkg::R_NOTICE, item_q.unit, tucst_pkg::M_RINGBACK,
								'0, 1'b0);
							r1 = mk(tucst_pkg::R_NOTICE, item_q.target, tucst_pkg::M_RINGING,
								'0, 1'b0);
						end
					end
				end
				tucst_pkg::K_CHAT: begin
					if (mode_u_q != tucst_pkg::M_CONNECTED) begin
						r0 = mk(tucst_pkg::R_REJECT, item_q.unit, tucst_pkg::M_ONHOOK, '0, 1'b1);
					end else if (lnk_u_q) begin
						two = 1'b1;
						r0  = mk(tucst_pkg::R_CHAT, peer_u_q, tucst_pkg::M_ONHOOK,
							item_q.unit, 1'b0);
						r1  = cur;
					end
				end
				default: begin
					r0 = cur;
				end
			endcase
		end
		r0.last = !two;
		r1.last = 1'b1;
	end

	always_comb begin
		state_d  = state_q;
		cmd_pop  = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = '0;
		we       = 1'b0;
		wa       = iu;
		wd       = wu_entry;
		res_push = 1'b0;
		res      = r0;
		commit   = 1'b0;
		case (state_q)
			tucst_pkg::B_IDLE: begin
				if (!cmd_stat.empty) begin
					cmd_pop = 1'b1;
					rd_en   = 1'b1;
					rd_addr = cmd_item.bad ? '0 : to_idx(cmd_item.unit);
					state_d = tucst_pkg::B_RDX;
				end
			end
			tucst_pkg::B_RDX: begin
				rd_en   = 1'b1;
				rd_addr = x_ok ? to_idx(x_sel) : '0;
				state_d = tucst_pkg::B_EXEC;
			end
			tucst_pkg::B_EXEC: begin
				if (!res_stat.full) begin
					commit   = 1'b1;
					res_push = 1'b1;
					we       = wu;
					state_d  = two ? tucst_pkg::B_SECOND : tucst_pkg::B_IDLE;
				end
			end
			tucst_pkg::B_SECOND: begin
				res = r1_q;
				wa  = ix_q;
				wd  = wx_entry_q;
				if (!res_stat.full) begin
					res_push = 1'b1;
					we       = wx_q;
					state_d  = tucst_pkg::B_IDLE;
				end
			end
			default: begin
				state_d = tucst_pkg::B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= tucst_pkg::B_IDLE;
			written_q <= '0;
			link_q    <= '0;
		end else begin
			state_q <= state_d;
			if (we) begin
				written_q[wa] <= 1'b1;
			end
			if (commit) begin
				if (lu_clr) begin
					link_q[iu] <= 1'b0;
				end else if (lu_set) begin
					link_q[iu] <= 1'b1;
				end
				if (lx_clr) begin
					link_q[ix_q] <= 1'b0;
				end else if (lx_set) begin
					link_q[ix_q] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
		if (cmd_pop) begin
			item_q <= cmd_item;
		end
		if (state_q == tucst_pkg::B_RDX) begin
			mode_u_q <= mode_u;
			lnk_u_q  <= link_q[iu];
			peer_u_q <= rdata_q.peer;
			x_q      <= x_sel;
			ix_q     <= x_ok ? to_idx(x_sel) : '0;
		end
		if (commit) begin
			r1_q       <= r1;
			wx_q       <= wx;
			wx_entry_q <= wx_entry;
		end
	end

	a_link_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tucst_pkg::B_EXEC && !item_q.bad && item_q.kind != tucst_pkg::K_DIAL &&
			lnk_u_q) |-> lnk_x)
		else $error("linked unit found with an unlinked peer");

	a_two_results: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tucst_pkg::B_EXEC && res_push && !res.last) |=> state_q == tucst_pkg::B_SECOND)
		else $error("first of two results not followed by the second");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res.last) |=> state_q == tucst_pkg::B_IDLE)
		else $error("event still active after its final result");

	a_no_write_bad: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> !item_q.bad)
		else $error("table written for an out-of-range unit");

endmodule

// File: rtl/telephone_unit_call_state_table.sv
// The command queue holds events while the back end works on one at a time: B_IDLE pops it and
// reads its own entry, B_RDX the peer or target entry, B_EXEC pushes the first result, B_SECOND
// any second; the single-port unit table takes these two reads and up to two writes per event.
// Reset (arst_n low, asynchronous): all units on hook, all links clear, queues empty.
// Table contents need no clearing pass; per-entry written bits cover them.
module telephone_unit_call_state_table #(
	parameter int UNIT_COUNT = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       event_valid,
	output logic       event_stall,
	input  logic [1:0] kind,
	input  logic [3:0] unit,
	input  logic [3:0] target_unit,
	input  logic       target_known,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [1:0] result_type,
	output logic [3:0] dest_unit,
	output logic [2:0] notice_state,
	output logic [3:0] notice_peer,
	output logic       error_flag,
	output logic       last
);

	localparam int ItemW = $bits(tucst_pkg::item_t);
	localparam int ResW  = $bits(tucst_pkg::result_t);

	tucst_pkg::fifo_stat_t cmd_stat, res_stat;
	tucst_pkg::item_t      front_item, cmd_item;
	tucst_pkg::result_t    back_res, out_res;
	logic                  front_push, cmd_pop, res_push, res_pop;
	logic [ItemW-1:0]      cmd_rdata;
	logic [ResW-1:0]       res_rdata;

	tucst_front #(.UNIT_COUNT(UNIT_COUNT)) u_front (
		.valid        (event_valid),
		.kind         (kind),
		.unit         (unit),
		.target_unit  (target_unit),
		.target_known (target_known),
		.q_stat       (cmd_stat),
		.stall        (event_stall),
		.push         (front_push),
		.item         (front_item)
	);

	tucst_fifo #(.WIDTH(ItemW), .DEPTH(2)) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (front_push),
		.wdata  (front_item),
		.pop    (cmd_pop),
		.rdata  (cmd_rdata),
		.stat   (cmd_stat)
	);

	assign cmd_item = tucst_pkg::item_t'(cmd_rdata);

	tucst_back #(.UNIT_COUNT(UNIT_COUNT)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_stat (cmd_stat),
		.cmd_item (cmd_item),
		.cmd_pop  (cmd_pop),
		.res_stat (res_stat),
		.res_push (res_push),
		.res      (back_res)
	);

	tucst_fifo #(.WIDTH(ResW), .DEPTH(2)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (back_res),
		.pop    (res_pop),
		.rdata  (res_rdata),
		.stat   (res_stat)
	);

	assign out_res      = tucst_pkg::result_t'(res_rdata);
	assign result_valid = !res_stat.empty;
	assign res_pop      = result_valid && !result_stall;
	assign result_type  = out_res.rtype;
	assign dest_unit    = out_res.dest;
	assign notice_state = out_res.state;
	assign notice_peer  = out_res.peer;
	assign error_flag   = out_res.err;
	assign last         = out_res.last;

endmodule

// File: tb/tb_telephone_unit_call_state_table.sv
module tb_telephone_unit_call_state_table;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		tucst_pkg::kind_t kind;
		tucst_pkg::ext_t  unit;
		tucst_pkg::ext_t  target;
		logic             known;
		bit               drain;
	} call_event_t;

	localparam int TargetEvents = 1200;
	localparam int PauseEvery = 450;
	localparam int HoldCycles = 250;
	localparam int MaxReports = 10;
	localparam int TailCycles = 20;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       event_valid = 1'b0;
	logic       event_stall;
	logic [1:0] kind = '0;
	logic [3:0] unit = '0;
	logic [3:0] target_unit = '0;
	logic       target_known = 1'b0;
	logic       result_valid;
	logic       result_stall = 1'b0;
	logic [1:0] result_type;
	logic [3:0] dest_unit;
	logic [2:0] notice_state;
	logic [3:0] notice_peer;
	logic       error_flag;
	logic       last;

	// predicted call table
	tucst_pkg::mode_t tbl_mode[tucst_pkg::MaxUnits];
	logic             tbl_linked[tucst_pkg::MaxUnits];
	tucst_pkg::ext_t  tbl_peer[tucst_pkg::MaxUnits];

	call_event_t          pending_calls[$];
	tucst_pkg::result_t   owed_results[$];
	call_event_t          on_line;

	logic ev_fire = 1'b0;
	logic long_hold = 1'b0;
	bit   drain_next = 1'b0;
	int   total_events = 0;
	int   events_taken = 0;
	int   results_seen = 0;
	int   mismatches = 0;
	int   calls_placed = 0;
	int   calls_answered = 0;

	telephone_unit_call_state_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.event_valid(event_valid),
		.event_stall(event_stall),
		.kind(kind),
		.unit(unit),
		.target_unit(target_unit),
		.target_known(target_known),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_type(result_type),
		.dest_unit(dest_unit),
		.notice_state(notice_state),
		.notice_peer(notice_peer),
		.error_flag(error_flag),
		.last(last)
	);

	always #1 clk = ~clk;

	function automatic tucst_pkg::result_t make_result(tucst_pkg::rtype_t rt,
		tucst_pkg::ext_t dest, tucst_pkg::mode_t st, tucst_pkg::ext_t peer, logic err);
		tucst_pkg::result_t r;
		r.rtype = rt;
		r.dest = dest;
		r.state = st;
		r.peer = peer;
		r.err = err;
		r.last = 1'b0;
		return r;
	endfunction

	// notice of the unit's present state; peer shown only when connected
	function automatic tucst_pkg::result_t state_notice(tucst_pkg::ext_t u);
		tucst_pkg::ext_t peer;
		peer = '0;
		if (tbl_mode[u] == tucst_pkg::M_CONNECTED && tbl_linked[u])
			peer = tbl_peer[u];
		return make_result(tucst_pkg::R_NOTICE, u, tbl_mode[u], peer, 1'b0);
	endfunction

	task automatic apply_call_event(input call_event_t ev);
		tucst_pkg::result_t outs[$];
		tucst_pkg::result_t r;
		tucst_pkg::mode_t   st;
		tucst_pkg::mode_t   pst;
		tucst_pkg::ext_t    u;
		tucst_pkg::ext_t    t;
		tucst_pkg::ext_t    p;
		u = ev.unit;
		t = ev.target;
		st = tbl_mode[u];
		p = tbl_peer[u];
		case (ev.kind)
			tucst_pkg::K_PICKUP: begin
				if (st == tucst_pkg::M_ONHOOK) begin
					tbl_mode[u] = tucst_pkg::M_DIALTONE;
					outs.push_back(state_notice(u));
				end else if (st == tucst_pkg::M_RINGING && tbl_linked[u]) begin
					tbl_mode[u] = tucst_pkg::M_CONNECTED;
					tbl_mode[p] = tucst_pkg::M_CONNECTED;
					outs.push_back(make_result(tucst_pkg::R_NOTICE, u,
						tucst_pkg::M_CONNECTED, p, 1'b0));
					outs.push_back(make_result(tucst_pkg::R_NOTICE, p,
						tucst_pkg::M_CONNECTED, u, 1'b0));
					calls_answered++;
				end else if (st == tucst_pkg::M_RINGING) begin
					tbl_mode[u] = tucst_pkg::M_CONNECTED;
					outs.push_back(make_result(tucst_pkg::R_NOTICE, u,
						tucst_pkg::M_CONNECTED, '0, 1'b0));
				end else begin
					outs.push_back(state_notice(u));
				end
			end
			tucst_pkg::K_HANGUP: begin
				tbl_mode[u] = tucst_pkg::M_ONHOOK;
				outs.push_back(make_result(tucst_pkg::R_NOTICE, u, tucst_pkg::M_ONHOOK,
					'0, 1'b0));
				if (st == tucst_pkg::M_CONNECTED || st == tucst_pkg::M_RINGING ||
					st == tucst_pkg::M_RINGBACK) begin
					// a caller dropped by its callee is left with dial tone
					if (tbl_linked[u]) begin
						if (st == tucst_pkg::M_RINGBACK)
							pst = tucst_pkg::M_ONHOOK;
						else
							pst = tucst_pkg::M_DIALTONE;
						tbl_mode[p] = pst;
						tbl_linked[p] = 1'b0;
						outs.push_back(make_result(tucst_pkg::R_NOTICE, p, pst, '0, 1'b0));
					end
					tbl_linked[u] = 1'b0;
				end
			end
			tucst_pkg::K_DIAL: begin
				if (!ev.known && st == tucst_pkg::M_DIALTONE) begin
					tbl_mode[u] = tucst_pkg::M_ERROR;
					outs.push_back(make_result(tucst_pkg::R_NOTICE, u, tucst_pkg::M_ERROR,
						'0, 1'b1));
				end else if (!ev.known || st != tucst_pkg::M_DIALTONE) begin
					outs.push_back(state_notice(u));
				end else if (t == u || tbl_linked[t] || tbl_mode[t] != tucst_pkg::M_ONHOOK) begin
					tbl_mode[u] = tucst_pkg::M_BUSY;
					outs.push_back(make_result(tucst_pkg::R_NOTICE, u, tucst_pkg::M_BUSY,
						'0, 1'b0));
				end else begin
					tbl_linked[u] = 1'b1;
					tbl_peer[u] = t;
					tbl_linked[t] = 1'b1;
					tbl_peer[t] = u;
					tbl_mode[u] = tucst_pkg::M_RINGBACK;
					tbl_mode[t] = tucst_pkg::M_RINGING;
					outs.push_back(make_result(tucst_pkg::R_NOTICE, u, tucst_pkg::M_RINGBACK,
						'0, 1'b0));
					outs.push_back(make_result(tucst_pkg::R_NOTICE, t, tucst_pkg::M_RINGING,
						'0, 1'b0));
					calls_placed++;
				end
			end
			default: begin
				if (st != tucst_pkg::M_CONNECTED) begin
					outs.push_back(make_result(tucst_pkg::R_REJECT, u, tucst_pkg::M_ONHOOK,
						'0, 1'b1));
				end else begin
					if (tbl_linked[u])
						outs.push_back(make_result(tucst_pkg::R_CHAT, p, tucst_pkg::M_ONHOOK,
							u, 1'b0));
					outs.push_back(state_notice(u));
				end
			end
		endcase
		for (int i = 0; i < outs.size(); i++) begin
			r = outs[i];
			r.last = (i == outs.size() - 1);
			owed_results.push_back(r);
		end
	endtask

	task automatic queue_call(input tucst_pkg::kind_t k, input int u, input int t,
		input int known);
		call_event_t ev;
		ev.kind = k;
		ev.unit = tucst_pkg::ext_t'(u);
		ev.target = tucst_pkg::ext_t'(t);
		ev.known = known[0];
		ev.drain = drain_next;
		drain_next = 1'b0;
		pending_calls.push_back(ev);
	endtask

	function automatic int idle_share(bit receiver);
		if (events_taken < total_events / 3)
			return receiver ? 46 : 24;
		if (events_taken < 2 * total_events / 3)
			return receiver ? 24 : 46;
		return 0;
	endfunction

	// compare results first, then predict the event taken at this edge
	always @(posedge clk) begin : check_and_predict
		tucst_pkg::result_t got;
		tucst_pkg::result_t want;
		ev_fire <= arst_n && event_valid && !event_stall;
		if (arst_n && result_valid && !result_stall) begin
			got.rtype = tucst_pkg::rtype_t'(result_type);
			got.dest = dest_unit;
			got.state = tucst_pkg::mode_t'(notice_state);
			got.peer = notice_peer;
			got.err = error_flag;
			got.last = last;
			results_seen++;
			if (owed_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MaxReports)
					$display({"%t unexpected result: type=%0d dest=%0d state=%0d",
						" peer=%0d err=%0d last=%0d"},
						$time, got.rtype, got.dest, got.state, got.peer, got.err, got.last);
			end else begin
				want = owed_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= MaxReports) begin
						$display({"%t result mismatch, expected: type=%0d dest=%0d",
							" state=%0d peer=%0d err=%0d last=%0d"},
							$time, want.rtype, want.dest, want.state, want.peer, want.err,
							want.last);
						$display({"%t                    actual: type=%0d dest=%0d",
							" state=%0d peer=%0d err=%0d last=%0d"},
							$time, got.rtype, got.dest, got.state, got.peer, got.err,
							got.last);
					end
				end
			end
		end
		if (arst_n && event_valid && !event_stall) begin
			apply_call_event(on_line);
			events_taken++;
		end
	end

	always @(negedge clk) begin : drive_events
		logic offer;
		if (arst_n) begin
			// hold the current event until its transfer
			offer = event_valid && !ev_fire;
			if (!offer && pending_calls.size() > 0
				&& !(pending_calls[0].drain && owed_results.size() != 0)
				&& $urandom_range(99) >= idle_share(1'b0)) begin
				on_line = pending_calls.pop_front();
				kind <= on_line.kind;
				unit <= on_line.unit;
				target_unit <= on_line.target;
				target_known <= on_line.known;
				offer = 1'b1;
			end
			event_valid <= offer;
		end
	end

	always @(negedge clk) begin : drive_result_stall
		if (arst_n)
			result_stall <= long_hold || ($urandom_range(99) < idle_share(1'b1));
	end

	// block the result side long enough for the event side to back up
	initial begin : receiver_hold
		int n;
		wait (arst_n);
		while (events_taken < total_events * 5 / 6)
			@(posedge clk);
		long_hold = 1'b1;
		for (n = 0; n < HoldCycles; n++)
			@(posedge clk);
		long_hold = 1'b0;
	end

	initial begin : watchdog
		#400000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : stimulus
		int a;
		int b;
		int next_pause;
		for (int i = 0; i < tucst_pkg::MaxUnits; i++) begin
			tbl_mode[i] = tucst_pkg::M_ONHOOK;
			tbl_linked[i] = 1'b0;
			tbl_peer[i] = '0;
		end

		// directed: every state and every odd path once
		queue_call(tucst_pkg::K_PICKUP, 0, 15, 1);
		queue_call(tucst_pkg::K_DIAL, 0, 1, 0);        // unknown from dial tone -> error
		queue_call(tucst_pkg::K_DIAL, 0, 1, 1);        // dial outside dial tone
		queue_call(tucst_pkg::K_PICKUP, 0, 0, 0);      // pickup while in error
		queue_call(tucst_pkg::K_HANGUP, 0, 0, 0);
		queue_call(tucst_pkg::K_HANGUP, 0, 15, 1);     // hangup while on hook
		queue_call(tucst_pkg::K_CHAT, 0, 0, 0);        // chat unconnected
		queue_call(tucst_pkg::K_PICKUP, 1, 0, 0);
		queue_call(tucst_pkg::K_DIAL, 1, 1, 1);        // self dial -> busy
		queue_call(tucst_pkg::K_PICKUP, 1, 0, 1);      // pickup while busy
		queue_call(tucst_pkg::K_PICKUP, 2, 0, 0);
		queue_call(tucst_pkg::K_DIAL, 2, 3, 1);        // ring back / ringing
		queue_call(tucst_pkg::K_PICKUP, 4, 0, 0);
		queue_call(tucst_pkg::K_DIAL, 4, 3, 1);        // target linked -> busy
		queue_call(tucst_pkg::K_PICKUP, 3, 0, 0);      // answer
		queue_call(tucst_pkg::K_CHAT, 2, 0, 0);
		queue_call(tucst_pkg::K_CHAT, 3, 15, 1);
		queue_call(tucst_pkg::K_DIAL, 3, 9, 0);        // unknown while connected
		queue_call(tucst_pkg::K_HANGUP, 2, 0, 0);      // peer back to dial tone
		queue_call(tucst_pkg::K_PICKUP, 5, 0, 0);
		queue_call(tucst_pkg::K_DIAL, 5, 3, 1);        // target off hook -> busy
		queue_call(tucst_pkg::K_PICKUP, 7, 0, 0);
		queue_call(tucst_pkg::K_DIAL, 7, 15, 1);
		queue_call(tucst_pkg::K_HANGUP, 15, 0, 0);     // callee drops while ringing
		queue_call(tucst_pkg::K_PICKUP, 9, 0, 0);
		queue_call(tucst_pkg::K_DIAL, 9, 10, 1);
		queue_call(tucst_pkg::K_HANGUP, 9, 0, 0);      // caller drops during ring back

		drain_next = 1'b1;
		next_pause = pending_calls.size() + PauseEvery;
		while (pending_calls.size() < TargetEvents) begin
			if (pending_calls.size() >= next_pause) begin
				drain_next = 1'b1;
				next_pause += PauseEvery;
			end
			if ($urandom_range(99) < 75) begin
				// one call attempt with random twists
				a = $urandom_range(15);
				b = $urandom_range(15);
				if ($urandom_range(2) == 0)
					queue_call(tucst_pkg::K_HANGUP, a, $urandom_range(15), $urandom_range(1));
				queue_call(tucst_pkg::K_PICKUP, a, $urandom_range(15), $urandom_range(1));
				queue_call(tucst_pkg::K_DIAL, a, b, $urandom_range(9) != 0);
				if ($urandom_range(3) != 0)
					queue_call(tucst_pkg::K_PICKUP, b, $urandom_range(15), $urandom_range(1));
				repeat ($urandom_range(3))
					queue_call(tucst_pkg::K_CHAT, $urandom_range(1) ? a : b,
						$urandom_range(15), $urandom_range(1));
				if ($urandom_range(3) != 0)
					queue_call(tucst_pkg::K_HANGUP, $urandom_range(1) ? a : b,
						$urandom_range(15), $urandom_range(1));
			end else begin
				repeat ($urandom_range(1, 3))
					queue_call(tucst_pkg::kind_t'($urandom_range(3)), $urandom_range(15),
						$urandom_range(15), $urandom_range(1));
			end
		end
		total_events = pending_calls.size();

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_calls.size() != 0 || event_valid || owed_results.size() != 0)
			@(posedge clk);
		repeat (TailCycles) @(posedge clk);

		$display("Sent %0d call events under shifting back-pressure, checked %0d results.",
			events_taken, results_seen);
		$display("Calls placed: %0d, answered: %0d, mismatches: %0d.",
			calls_placed, calls_answered, mismatches);
		if (mismatches == 0 && owed_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: telephone_unit_call_state_table.f
rtl/tucst_pkg.sv
rtl/tucst_fifo.sv
rtl/tucst_front.sv
rtl/tucst_back.sv
rtl/telephone_unit_call_state_table.sv
tb/tb_telephone_unit_call_state_table.sv
